// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// depends on clk and rst_n being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSER_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RSER_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSER_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSER_ASSERT(lbl, cond, msg)
`define RSER_ASSERT_IMP(lbl, ante, cons, msg)
`define RSER_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/rser_pkg.sv -----
// shared types and constants of the rtp sequence extend and reorder block
// no dependencies
package rser_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SEQ_W           = 32;
    localparam int LOW_W           = 16;
    localparam int TAG_W           = 32;
    localparam int CNT_OUT_W       = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        logic             lt;
        logic             eq;
        logic [SEQ_W-1:0] delta;
    } cmp_res_t;

endpackage

// ----- rtl/rser_cmp.sv -----
// shared 32-bit compare unit: less-than, equal and absolute distance
// depends on rser_pkg
module rser_cmp
(
    input  logic [rser_pkg::SEQ_W-1:0] a,
    input  logic [rser_pkg::SEQ_W-1:0] b,
    output rser_pkg::cmp_res_t         res
);

    logic [rser_pkg::SEQ_W:0] diff;

    assign diff      = {1'b0, a} - {1'b0, b};
    assign res.lt    = diff[rser_pkg::SEQ_W];
    assign res.eq    = (a == b);
    assign res.delta = diff[rser_pkg::SEQ_W] ? (~diff[rser_pkg::SEQ_W-1:0] + 1'b1)
                                             : diff[rser_pkg::SEQ_W-1:0];

endmodule

// ----- rtl/rser_queue_ram.sv -----
// queue storage: one write port, one read port with registered read data
// no dependencies
module rser_queue_ram
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 64
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/rtp_sequence_extend_reorder_top.sv -----
// top level: sequencer, sequence extension and sorted reorder queue
// depends on rser_pkg, rser_cmp, rser_queue_ram and assert_macros.svh
//
// Each request is either an insert of a packet (16-bit sequence number plus a
// 32-bit payload handle) or a pop of the lowest-numbered queued packet, and
// gives exactly one result. Inserts are extended to 32 bits against the
// highest number seen and kept in an ascending queue of QUEUE_DEPTH entries.
// All compares and distances run through one 32-bit compare/subtract unit
// and the queue lives in a memory with one read and one write port, so
// requests are handled one at a time. An insert scans the queue for its
// place and shifts the larger entries up; a duplicate ends as soon as it is
// found, and a finished request waits until the last result is taken. A new
// request is taken while the last result still waits at the output.
`include "assert_macros.svh"
module rtp_sequence_extend_reorder_top
#(
    parameter int QUEUE_DEPTH = rser_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] seq_low,
    input  logic [31:0] packet_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] ext_seq,
    output logic [31:0] tag_out,
    output logic [31:0] highest_seq,
    output logic [4:0]  queue_count
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int SQ   = rser_pkg::SEQ_W;
    localparam int TW   = rser_pkg::TAG_W;
    localparam int LW   = rser_pkg::LOW_W;
    localparam int HW   = SQ - LW;
    localparam int OW   = rser_pkg::CNT_OUT_W;
    localparam int RW   = SQ + TW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D_SAME,
        S_D_NEXT,
        S_D_PREV,
        S_PICK1,
        S_PICK2,
        S_HIGH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PLACE,
        S_SH_RD,
        S_SH_WR,
        S_POP_TAKE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                seen_reg, seen_next;
    logic [SQ-1:0]       high_reg, high_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [LW-1:0]       low_reg, low_next;
    logic [TW-1:0]       tag_reg, tag_next;
    logic [SQ-1:0]       ext_reg, ext_next;
    logic [TW-1:0]       res_tag_reg, res_tag_next;
    rser_pkg::status_t   res_status_reg, res_status_next;
    logic [SQ-1:0]       d_same_reg, d_same_next;
    logic [SQ-1:0]       d_next_reg, d_next_next;
    logic [SQ-1:0]       d_prev_reg, d_prev_next;
    logic                lt1_reg, lt1_next;
    logic                out_valid_reg, out_valid_next;
    rser_pkg::status_t   status_reg, status_next;
    logic [SQ-1:0]       ext_seq_reg, ext_seq_next;
    logic [TW-1:0]       tag_out_reg, tag_out_next;
    logic [SQ-1:0]       highest_out_reg, highest_out_next;
    logic [OW-1:0]       count_out_reg, count_out_next;

    logic [SQ-1:0]       cmp_a, cmp_b;
    rser_pkg::cmp_res_t  cmp_res;
    logic [SQ-1:0]       c_same, c_next, c_prev;
    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [RW-1:0]       wr_data, rd_data;
    logic [SQ-1:0]       rd_seq;
    logic [TW-1:0]       rd_tag;
    logic [31:0]         count_wide;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = {1'b0, base} + SW'(off);
        if (s >= SW'(QUEUE_DEPTH))
        begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // candidates in the same, next and previous 64k window
    assign c_same = {high_reg[SQ-1:LW], low_reg};
    assign c_next = {high_reg[SQ-1:LW] + HW'(1), low_reg};
    assign c_prev = {high_reg[SQ-1:LW] - HW'(1), low_reg};

    assign rd_seq = rd_data[RW-1:TW];
    assign rd_tag = rd_data[TW-1:0];

    rser_cmp u_cmp
    (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    rser_queue_ram
    #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .WIDTH (RW)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign count_wide = {{(32 - CW){1'b0}}, count_reg};

    always_comb
    begin
        state_next       = state_reg;
        seen_next        = seen_reg;
        high_next        = high_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        low_next         = low_reg;
        tag_next         = tag_reg;
        ext_next         = ext_reg;
        res_tag_next     = res_tag_reg;
        res_status_next  = res_status_reg;
        d_same_next      = d_same_reg;
        d_next_next      = d_next_reg;
        d_prev_next      = d_prev_reg;
        lt1_next         = lt1_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        ext_seq_next     = ext_seq_reg;
        tag_out_next     = tag_out_reg;
        highest_out_next = highest_out_reg;
        count_out_next   = count_out_reg;
        cmp_a            = high_reg;
        cmp_b            = ext_reg;
        rd_addr          = head_reg;
        wr_en            = 1'b0;
        wr_addr          = phys(head_reg, k_reg);
        wr_data          = {ext_reg, tag_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    low_next     = seq_low;
                    tag_next     = packet_tag;
                    res_tag_next = '0;
                    k_next       = '0;
                    if (action == rser_pkg::ACT_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            ext_next        = '0;
                            res_status_next = rser_pkg::ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP_TAKE;
                        end
                    end
                    else if (!seen_reg)
                    begin
                        seen_next  = 1'b1;
                        ext_next   = {{HW{1'b0}}, seq_low};
                        high_next  = {{HW{1'b0}}, seq_low};
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_D_SAME;
                    end
                end
            end
            S_D_SAME:
            begin
                cmp_a       = c_same;
                cmp_b       = high_reg;
                d_same_next = cmp_res.delta;
                state_next  = S_D_NEXT;
            end
            S_D_NEXT:
            begin
                cmp_a       = c_next;
                cmp_b       = high_reg;
                d_next_next = cmp_res.delta;
                state_next  = S_D_PREV;
            end
            S_D_PREV:
            begin
                cmp_a       = c_prev;
                cmp_b       = high_reg;
                d_prev_next = cmp_res.delta;
                state_next  = S_PICK1;
            end
            S_PICK1:
            begin
                cmp_a      = d_same_reg;
                cmp_b      = d_next_reg;
                lt1_next   = cmp_res.lt;
                state_next = S_PICK2;
            end
            S_PICK2:
            begin
                cmp_a = lt1_reg ? d_same_reg : d_next_reg;
                cmp_b = d_prev_reg;
                if (cmp_res.lt)
                begin
                    ext_next = lt1_reg ? c_same : c_next;
                end
                else
                begin
                    ext_next = c_prev;
                end
                state_next = S_HIGH;
            end
            S_HIGH:
            begin
                cmp_a = high_reg;
                cmp_b = ext_reg;
                if (cmp_res.lt)
                begin
                    high_next = ext_reg;
                end
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    rd_addr    = phys(head_reg, k_reg);
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                cmp_a = rd_seq;
                cmp_b = ext_reg;
                if (cmp_res.eq)
                begin
                    res_status_next = rser_pkg::ST_DUPLICATE;
                    state_next      = S_DONE;
                end
                else if (cmp_res.lt)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res_status_next = rser_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (j_reg == k_reg)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = phys(head_reg, k_reg);
                    wr_data         = {ext_reg, tag_reg};
                    count_next      = count_reg + 1'b1;
                    res_status_next = rser_pkg::ST_INSERTED;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr    = phys(head_reg, j_reg - 1'b1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, j_reg);
                wr_data    = rd_data;
                j_next     = j_reg - 1'b1;
                state_next = S_SH_RD;
            end
            S_POP_TAKE:
            begin
                ext_next        = rd_seq;
                res_tag_next    = rd_tag;
                head_next       = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_reg + 1'b1;
                count_next      = count_reg - 1'b1;
                res_status_next = rser_pkg::ST_POPPED;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    ext_seq_next     = ext_reg;
                    tag_out_next     = res_tag_reg;
                    highest_out_next = high_reg;
                    count_out_next   = count_wide[OW-1:0];
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seen_reg        <= 1'b0;
            high_reg        <= '0;
            count_reg       <= '0;
            head_reg        <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            low_reg         <= '0;
            tag_reg         <= '0;
            ext_reg         <= '0;
            res_tag_reg     <= '0;
            res_status_reg  <= rser_pkg::ST_INSERTED;
            d_same_reg      <= '0;
            d_next_reg      <= '0;
            d_prev_reg      <= '0;
            lt1_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= rser_pkg::ST_INSERTED;
            ext_seq_reg     <= '0;
            tag_out_reg     <= '0;
            highest_out_reg <= '0;
            count_out_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            seen_reg        <= seen_next;
            high_reg        <= high_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            k_reg           <= k_next;
            j_reg           <= j_next;
            low_reg         <= low_next;
            tag_reg         <= tag_next;
            ext_reg         <= ext_next;
            res_tag_reg     <= res_tag_next;
            res_status_reg  <= res_status_next;
            d_same_reg      <= d_same_next;
            d_next_reg      <= d_next_next;
            d_prev_reg      <= d_prev_next;
            lt1_reg         <= lt1_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            ext_seq_reg     <= ext_seq_next;
            tag_out_reg     <= tag_out_next;
            highest_out_reg <= highest_out_next;
            count_out_reg   <= count_out_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign ext_seq     = ext_seq_reg;
    assign tag_out     = tag_out_reg;
    assign highest_seq = highest_out_reg;
    assign queue_count = count_out_reg;

    `RSER_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "queue count above depth")
    `RSER_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state_reg != S_IDLE, "request not taken")
    `RSER_ASSERT_IMP(a_scan_in_range, state_reg == S_SCAN_CMP, k_reg < count_reg, "scan past tail")
    `RSER_ASSERT_NXT(a_insert_grows, state_reg == S_SH_RD && j_reg == k_reg, count_reg == $past(count_reg) + 1'b1, "insert lost count")
    `RSER_ASSERT_IMP(a_full_only_at_depth, state_reg == S_PLACE && count_reg != CW'(QUEUE_DEPTH), state_next == S_SH_RD, "drop below depth")

endmodule

// ----- tb/rser_result_checker.sv -----
// result checker for the rtp sequence extend and reorder block
// keeps its own copy of the extension and sorted queue state, compares every result
// depends on rser_pkg
`timescale 1ns / 100ps
module rser_result_checker
#(
    parameter int DEPTH = rser_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [15:0] seq_low,
    input  logic [31:0] packet_tag,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] ext_seq,
    input  logic [31:0] tag_out,
    input  logic [31:0] highest_seq,
    input  logic [4:0]  queue_count,
    output int          fail_count,
    output int          awaiting,
    output int          results_checked,
    output int          inserted_n,
    output int          duplicate_n,
    output int          full_n,
    output int          popped_n,
    output int          empty_n
);

    typedef struct {
        rser_pkg::status_t st;
        logic [31:0]       ext;
        logic [31:0]       tag;
        logic [31:0]       peak;
        logic [4:0]        cnt;
    } step_result_t;

    typedef struct {
        logic [31:0] seq;
        logic [31:0] tag;
    } held_packet_t;

    bit           seen_any;
    logic [31:0]  peak_ext;
    held_packet_t held[$];
    step_result_t awaited[$];

    function automatic logic [31:0] span(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // pick the window nearest the highest number, ties as the block resolves them
    function automatic logic [31:0] unwrap_seq(input logic [15:0] low,
                                               input logic [31:0] peak);
        logic [15:0] hi_next;
        logic [15:0] hi_prev;
        logic [31:0] c_same;
        logic [31:0] c_next;
        logic [31:0] c_prev;
        logic [31:0] d_same;
        logic [31:0] d_next;
        logic [31:0] d_prev;
        hi_next = peak[31:16] + 16'd1;
        hi_prev = peak[31:16] - 16'd1;
        c_same  = {peak[31:16], low};
        c_next  = {hi_next, low};
        c_prev  = {hi_prev, low};
        d_same  = span(c_same, peak);
        d_next  = span(c_next, peak);
        d_prev  = span(c_prev, peak);
        if (d_same < d_next)
            return (d_same < d_prev) ? c_same : c_prev;
        return (d_next < d_prev) ? c_next : c_prev;
    endfunction

    function automatic void advance_reorder_model(input logic act, input logic [15:0] low,
                                                  input logic [31:0] tag,
                                                  output step_result_t res);
        held_packet_t pkt;
        int           pos;
        res.st  = rser_pkg::ST_EMPTY;
        res.ext = '0;
        res.tag = '0;
        if (act == rser_pkg::ACT_INSERT) begin
            if (!seen_any) begin
                seen_any = 1'b1;
                res.ext  = {16'd0, low};
                peak_ext = res.ext;
            end
            else
            begin
                res.ext = unwrap_seq(low, peak_ext);
                if (res.ext > peak_ext)
                    peak_ext = res.ext;
            end
            pos = 0;
            while (pos < held.size() && held[pos].seq < res.ext)
                pos++;
            if (pos < held.size() && held[pos].seq == res.ext)
                res.st = rser_pkg::ST_DUPLICATE;
            else if (held.size() >= DEPTH)
                res.st = rser_pkg::ST_FULL;
            else
            begin
                pkt.seq = res.ext;
                pkt.tag = tag;
                held.insert(pos, pkt);
                res.st = rser_pkg::ST_INSERTED;
            end
        end
        else if (held.size() != 0)
        begin
            pkt     = held.pop_front();
            res.st  = rser_pkg::ST_POPPED;
            res.ext = pkt.seq;
            res.tag = pkt.tag;
        end
        res.peak = peak_ext;
        res.cnt  = 5'(held.size());
        case (res.st)
            rser_pkg::ST_INSERTED:  inserted_n++;
            rser_pkg::ST_DUPLICATE: duplicate_n++;
            rser_pkg::ST_FULL:      full_n++;
            rser_pkg::ST_POPPED:    popped_n++;
            default:                empty_n++;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_result_t want;
        if (!rst_n) begin
            seen_any = 1'b0;
            peak_ext = '0;
            held.delete();
            awaited.delete();
            awaiting = 0;
        end
        else
        begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (awaited.size() == 0) begin
                    $error("result with no request outstanding: status %0d", status);
                    fail_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    compare_field("status", 32'(want.st), 32'(status));
                    compare_field("ext_seq", want.ext, ext_seq);
                    compare_field("tag_out", want.tag, tag_out);
                    compare_field("highest_seq", want.peak, highest_seq);
                    compare_field("queue_count", 32'(want.cnt), 32'(queue_count));
                end
            end
            if (in_valid && in_ready) begin
                advance_reorder_model(action, seq_low, packet_tag, want);
                awaited.insert(awaited.size(), want);
            end
            awaiting = awaited.size();
        end
    end

endmodule

// ----- tb/rtp_sequence_extend_reorder_top_tb.sv -----
// testbench top for rtp_sequence_extend_reorder_top: clock, reset, requests and verdict
// drives directed then random packet streams with random idling on both channels
// depends on rser_pkg, the block and rser_result_checker
`timescale 1ns / 100ps
module rtp_sequence_extend_reorder_top_tb;

    localparam int LIMIT_CYCLES    = 1_500_000;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int DRAIN_CYCLES    = 150;
    localparam int LONG_HOLD       = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [15:0] seq_low;
    logic [31:0] packet_tag;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] ext_seq;
    logic [31:0] tag_out;
    logic [31:0] highest_seq;
    logic [4:0]  queue_count;

    int fail_count;
    int awaiting;
    int results_checked;
    int inserted_n;
    int duplicate_n;
    int full_n;
    int popped_n;
    int empty_n;
    int cycle_count = 0;
    bit sender_steady;

    rtp_sequence_extend_reorder_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .seq_low     (seq_low),
        .packet_tag  (packet_tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .ext_seq     (ext_seq),
        .tag_out     (tag_out),
        .highest_seq (highest_seq),
        .queue_count (queue_count)
    );

    rser_result_checker result_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .seq_low         (seq_low),
        .packet_tag      (packet_tag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .ext_seq         (ext_seq),
        .tag_out         (tag_out),
        .highest_seq     (highest_seq),
        .queue_count     (queue_count),
        .fail_count      (fail_count),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .inserted_n      (inserted_n),
        .duplicate_n     (duplicate_n),
        .full_n          (full_n),
        .popped_n        (popped_n),
        .empty_n         (empty_n)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** rtp_sequence_extend_reorder_top: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'h0;
        if (r < 10)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // one request; returns at the edge where it was accepted
    task automatic send_request(input logic act, input logic [15:0] low,
                                input logic [31:0] tag);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        seq_low    <= low;
        packet_tag <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle_all();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
    endtask

    // result side: random stalls, one long hold while requests keep coming
    initial
    begin : result_sink
        int  stall_len;
        int  run_len;
        bit  long_done;
        out_ready = 1'b0;
        long_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!long_done && results_checked >= 300) begin
                long_done = 1'b1;
                stall_len = LONG_HOLD;
            end
            else
                stall_len = pick_gap();
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
            repeat (stall_len)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
            end
            repeat (run_len)
            begin
                @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int          k;
        int          pop_pct;
        int          r;
        logic [15:0] wire_seq;
        logic [15:0] low;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = rser_pkg::ACT_INSERT;
        seq_low       = '0;
        packet_tag    = '0;
        sender_steady = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop before any packet, first packet, wraps, ties, duplicates, full queue
        send_request(rser_pkg::ACT_POP, 16'h0000, 32'h0);
        send_request(rser_pkg::ACT_INSERT, 16'hffff, 32'hffff_ffff);
        send_request(rser_pkg::ACT_INSERT, 16'h0000, 32'h0);
        send_request(rser_pkg::ACT_INSERT, 16'hfffe, 32'ha5a5_a5a5);
        send_request(rser_pkg::ACT_INSERT, 16'h0000, 32'h5a5a_5a5a);
        send_request(rser_pkg::ACT_INSERT, 16'h8000, 32'h0000_0001);
        send_request(rser_pkg::ACT_INSERT, 16'h7fff, 32'h8000_0000);
        send_request(rser_pkg::ACT_INSERT, 16'hffff, 32'h1234_5678);
        send_request(rser_pkg::ACT_INSERT, 16'h8000, 32'hffff_ffff);
        send_request(rser_pkg::ACT_INSERT, 16'h0000, 32'h0);
        for (k = 1; k <= 10; k++)
            send_request(rser_pkg::ACT_INSERT, 16'(k), random_tag());
        send_request(rser_pkg::ACT_INSERT, 16'h0001, 32'hdead_beef);
        for (k = 0; k < 3; k++)
            send_request(rser_pkg::ACT_POP, 16'hffff, 32'hffff_ffff);
        settle_all();

        wire_seq = 16'($urandom);
        pop_pct  = 40;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 60 == 0) begin
                pop_pct       = $urandom_range(15, 65);
                sender_steady = ($urandom_range(0, 3) == 0);
            end
            if (n % 400 == 399)
                settle_all();
            if ($urandom_range(0, 99) < pop_pct)
                send_request(rser_pkg::ACT_POP, 16'($urandom), random_tag());
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    wire_seq = wire_seq + 16'd1;
                    low      = wire_seq;
                end
                else if (r < 82)
                    low = wire_seq - 16'($urandom_range(1, 8));
                else if (r < 90)
                    low = wire_seq - 16'($urandom_range(0, 2));
                else if (r < 95)
                begin
                    wire_seq = wire_seq + 16'($urandom_range(100, 40000));
                    low      = wire_seq;
                end
                else
                    low = 16'($urandom);
                send_request(rser_pkg::ACT_INSERT, low, random_tag());
            end
        end
        settle_all();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d duplicates, %0d full drops, %0d pops, %0d empty pops",
                 inserted_n, duplicate_n, full_n, popped_n, empty_n);
        $display("%0d results checked, highest extended number reached 0x%08h",
                 results_checked, highest_seq);
        if (fail_count == 0)
            $display("** rtp_sequence_extend_reorder_top: PASSED **");
        else
            $display("** rtp_sequence_extend_reorder_top: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rser_pkg.sv
rtl/rser_cmp.sv
rtl/rser_queue_ram.sv
rtl/rtp_sequence_extend_reorder_top.sv
tb/rser_result_checker.sv
tb/rtp_sequence_extend_reorder_top_tb.sv
